// ----- sv/ir_pulse_capture_replay_defines.svh -----
// Assertion macros for the IR pulse capture and replay block.
`ifndef IR_PULSE_CAPTURE_REPLAY_DEFINES_SVH
`define IR_PULSE_CAPTURE_REPLAY_DEFINES_SVH

`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define IPCR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("ipcr assertion failed");
// Check that the consequent holds whenever the antecedent holds.
`define IPCR_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ipcr implication failed");
`else
`define IPCR_ASSERT(lbl, clk, rst, prop)
`define IPCR_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- sv/ipcr_pkg.sv -----
// Shared constants and codes for the IR pulse capture and replay block.
package ipcr_pkg;

   localparam int IPCR_BUFFER_DEPTH    = 512;
   localparam int IPCR_TRAILER_PERIODS = 4;
   localparam logic [15:0] TRAILER_TICKS = 16'hFFFF;

   localparam int DATA_W = 16;

   localparam logic [15:0] GAP_MARK = 16'hFFFF;

   // transaction function codes
   localparam logic [2:0] FN_CAPTURE = 3'd0;
   localparam logic [2:0] FN_COMPARE = 3'd1;
   localparam logic [2:0] FN_START   = 3'd2;
   localparam logic [2:0] FN_WRITE   = 3'd3;
   localparam logic [2:0] FN_READ    = 3'd4;
   localparam logic [2:0] FN_RELEASE = 3'd5;
   localparam logic [2:0] FN_GO_IDLE = 3'd6;

   // operating phases
   localparam logic [2:0] PH_IDLE        = 3'd0;
   localparam logic [2:0] PH_RECVING     = 3'd1;
   localparam logic [2:0] PH_RECVED      = 3'd2;
   localparam logic [2:0] PH_RECVED_IDLE = 3'd3;
   localparam logic [2:0] PH_XMIT        = 3'd4;

   // compare unit actions
   localparam logic [1:0] CM_KEEP    = 2'd0;
   localparam logic [1:0] CM_DISABLE = 2'd1;
   localparam logic [1:0] CM_ARM     = 2'd2;
   localparam logic [1:0] CM_ADVANCE = 2'd3;

endpackage

// ----- sv/ipcr_buf.sv -----
// Interval buffer: one write port and one registered read port.
module ipcr_buf
   import ipcr_pkg::*;
#(
   parameter int DEPTH = IPCR_BUFFER_DEPTH,
   parameter int AW    = $clog2(IPCR_BUFFER_DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- sv/ir_pulse_capture_replay.sv -----
// Top level of the IR pulse capture and replay engine.
//
// Usage: every request transaction on req_* carries a function code (capture
// edge, compare match, start transmit, write entry, read entry, release, go
// idle) plus its operands, and yields exactly one response transaction on
// rsp_* with the phase, entry count, carrier and capture flags, the compare
// action for the timer and, for reads, the entry value.
// Path to rsp_valid: host writes, release, go idle, rising and first falling
// edges, receive compares and ignored events go straight to S_DONE; reads and
// transmit start add a buffer read step (S_READ, S_START), transmit compares
// that go on with the walk add S_XMIT1, one that skips a zero entry also S_XMIT2;
// a falling edge that backfills missed trailer periods writes them in S_PUSH.
// One item is in flight at a time and the next request is taken at the earliest
// at the edge that ends the first rsp_valid cycle; the interval memory has one
// write port and one registered read port.
// The response sits in an output register: a new request is accepted while
// an earlier response still waits, and the engine only holds in its final
// step when that register is still full and rsp_ready is low.
// Reset (synchronous, active high) returns to idle with capture enabled,
// count zero and the carrier off; buffer contents are not cleared and
// entries at or past the count read as zero.
module ir_pulse_capture_replay
   import ipcr_pkg::*;
#(
   parameter int BUFFER_DEPTH    = IPCR_BUFFER_DEPTH,
   parameter int TRAILER_PERIODS = IPCR_TRAILER_PERIODS
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [15:0] req_timestamp,
   input  logic [8:0]  req_index,
   input  logic [15:0] req_data,
   input  logic [9:0]  req_length,
   input  logic        req_use_40k,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_mode,
   output logic [15:0] rsp_read_data,
   output logic        rsp_accepted,
   output logic [9:0]  rsp_entry_count,
   output logic        rsp_carrier_on,
   output logic        rsp_carrier_40k,
   output logic        rsp_capture_enabled,
   output logic        rsp_capture_rising,
   output logic [1:0]  rsp_compare_mode,
   output logic [15:0] rsp_compare_delay
);

`include "ir_pulse_capture_replay_defines.svh"

   localparam int AW     = $clog2(BUFFER_DEPTH);
   localparam int CNT_W  = $clog2(BUFFER_DEPTH + 2);
   localparam int WIDE_W = CNT_W + 10;
   localparam int PUSH_W = $clog2(2 * TRAILER_PERIODS + 2);

   localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(BUFFER_DEPTH);
   localparam logic [WIDE_W-1:0] DEPTH_W = WIDE_W'(BUFFER_DEPTH);
   localparam logic [2:0]        TP_C    = 3'(TRAILER_PERIODS);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_XMIT1 = 3'd2;
   localparam logic [2:0] S_XMIT2 = 3'd3;
   localparam logic [2:0] S_READ  = 3'd4;
   localparam logic [2:0] S_PUSH  = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [2:0]        phase_ff, phase_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  play_ff, play_in;
   logic [15:0]       last_edge_ff, last_edge_in;
   logic [2:0]        trailer_ff, trailer_in;
   logic              expect_ff, expect_in;
   logic              capture_ff, capture_in;
   logic              compare_ff, compare_in;
   logic              burst_ff, burst_in;
   logic              freq_ff, freq_in;

   // per-transaction working registers
   logic [PUSH_W-1:0] push_left_ff, push_left_in;
   logic [15:0]       width_ff, width_in;
   logic              rd_ok_ff, rd_ok_in;
   logic [15:0]       rdata_ff, rdata_in;
   logic              acc_ff, acc_in;
   logic [1:0]        cmode_ff, cmode_in;
   logic [15:0]       cdelay_ff, cdelay_in;

   logic              rsp_valid_ff;
   logic              rsp_load;

   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [15:0]       mem_wdata;
   logic [AW-1:0]     mem_raddr;
   logic [15:0]       mem_q;

   logic              req_fire;
   logic              cap_ri;
   logic              cmp_to_idle;
   logic              go_idle;
   logic [2:0]        eff_phase;
   logic [CNT_W-1:0]  eff_count;
   logic              eff_expect;
   logic [15:0]       edge_width;
   logic [2:0]        missed;
   logic              play_done;
   logic              play_next_ok;
   logic [15:0]       push_value;

   ipcr_buf #(
      .DEPTH (BUFFER_DEPTH),
      .AW    (AW)
   ) u_buf (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_q)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   // Capture in received idle drops to idle before handling the edge.
   assign cap_ri = (req_func == FN_CAPTURE) && capture_ff && (phase_ff == PH_RECVED_IDLE);

   // Compare that ends a transmit walk or arrives outside receive/transmit.
   assign play_done = (play_ff >= count_ff) || (play_ff >= DEPTH_C);
   assign cmp_to_idle = (req_func == FN_COMPARE) && compare_ff &&
                        (((phase_ff == PH_XMIT) && play_done) ||
                         ((phase_ff != PH_XMIT) && (phase_ff != PH_RECVING)));

   assign go_idle = (req_func == FN_GO_IDLE) || cap_ri || cmp_to_idle;

   assign eff_phase  = cap_ri ? PH_IDLE : phase_ff;
   assign eff_count  = cap_ri ? '0 : count_ff;
   assign eff_expect = cap_ri ? 1'b0 : expect_ff;
   assign edge_width = req_timestamp - last_edge_ff;
   assign missed     = (trailer_ff <= TP_C) ? (TP_C - trailer_ff) : 3'd0;

   // Second read of a skip: position already advanced past the zero entry.
   assign play_next_ok = (play_ff < count_ff) && (play_ff < DEPTH_C);

   // Backfill order: 65535 then 0 for each missed period, the edge width last.
   assign push_value = (push_left_ff == PUSH_W'(1)) ? width_ff :
                       (push_left_ff[0] ? GAP_MARK : 16'd0);

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      play_in      = play_ff;
      last_edge_in = last_edge_ff;
      trailer_in   = trailer_ff;
      expect_in    = expect_ff;
      capture_in   = capture_ff;
      compare_in   = compare_ff;
      burst_in     = burst_ff;
      freq_in      = freq_ff;
      push_left_in = push_left_ff;
      width_in     = width_ff;
      rd_ok_in     = rd_ok_ff;
      rdata_in     = rdata_ff;
      acc_in       = acc_ff;
      cmode_in     = cmode_ff;
      cdelay_in    = cdelay_ff;
      mem_we       = 1'b0;
      mem_waddr    = count_ff[AW-1:0];
      mem_wdata    = push_value;
      mem_raddr    = play_ff[AW-1:0];
      rsp_load     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in  = S_DONE;
               rdata_in  = 16'd0;
               acc_in    = 1'b1;
               cmode_in  = CM_KEEP;
               cdelay_in = 16'd0;

               if (go_idle) begin
                  burst_in   = 1'b0;
                  cmode_in   = CM_DISABLE;
                  cdelay_in  = 16'd0;
                  compare_in = 1'b0;
                  expect_in  = 1'b0;
                  capture_in = 1'b1;
                  count_in   = '0;
                  play_in    = '0;
                  freq_in    = 1'b0;
                  phase_in   = PH_IDLE;
               end

               unique case (req_func)
                  FN_CAPTURE: begin
                     if (capture_ff && ((eff_phase == PH_IDLE) || (eff_phase == PH_RECVING))
                         && (eff_count < DEPTH_C)) begin
                        last_edge_in = req_timestamp;
                        if (eff_expect) begin
                           // rising edge: store low width, arm the trailer timer
                           mem_we     = 1'b1;
                           mem_waddr  = eff_count[AW-1:0];
                           mem_wdata  = edge_width;
                           count_in   = eff_count + CNT_W'(1);
                           expect_in  = 1'b0;
                           cmode_in   = CM_ARM;
                           cdelay_in  = TRAILER_TICKS;
                           compare_in = 1'b1;
                           trailer_in = TP_C;
                        end else if (eff_phase == PH_IDLE) begin
                           // first falling edge: open a capture, drop its width
                           count_in   = '0;
                           play_in    = '0;
                           phase_in   = PH_RECVING;
                           expect_in  = 1'b1;
                           cmode_in   = CM_DISABLE;
                           compare_in = 1'b0;
                        end else begin
                           width_in     = edge_width;
                           push_left_in = PUSH_W'({missed, 1'b1});
                           expect_in    = 1'b1;
                           cmode_in     = CM_DISABLE;
                           cdelay_in    = 16'd0;
                           compare_in   = 1'b0;
                           state_in     = S_PUSH;
                        end
                     end
                  end
                  FN_COMPARE: begin
                     if (compare_ff && !cmp_to_idle) begin
                        if (phase_ff == PH_XMIT) begin
                           mem_raddr = play_ff[AW-1:0];
                           play_in   = play_ff + CNT_W'(1);
                           state_in  = S_XMIT1;
                        end else if (trailer_ff != 3'd0) begin
                           trailer_in = trailer_ff - 3'd1;
                           if (trailer_ff == 3'd1) begin
                              cmode_in   = CM_DISABLE;
                              compare_in = 1'b0;
                              capture_in = 1'b0;
                              phase_in   = PH_RECVED;
                           end
                        end
                     end
                  end
                  FN_START: begin
                     if ((req_length != 10'd0) && (WIDE_W'(req_length) <= DEPTH_W) &&
                         ((phase_ff == PH_IDLE) || (phase_ff == PH_RECVED_IDLE))) begin
                        count_in   = CNT_W'(req_length);
                        phase_in   = PH_XMIT;
                        capture_in = 1'b0;
                        freq_in    = req_use_40k;
                        burst_in   = 1'b1;
                        compare_in = 1'b1;
                        mem_raddr  = '0;
                        play_in    = CNT_W'(1);
                        state_in   = S_START;
                     end else begin
                        acc_in = 1'b0;
                     end
                  end
                  FN_WRITE: begin
                     if (WIDE_W'(req_index) < DEPTH_W) begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(req_index);
                        mem_wdata = req_data;
                        if (WIDE_W'(req_index) + WIDE_W'(1) > WIDE_W'(count_ff)) begin
                           count_in = CNT_W'(WIDE_W'(req_index) + WIDE_W'(1));
                        end
                     end
                  end
                  FN_READ: begin
                     rd_ok_in  = (WIDE_W'(req_index) < WIDE_W'(count_ff)) &&
                                 (WIDE_W'(req_index) < DEPTH_W);
                     mem_raddr = AW'(req_index);
                     state_in  = S_READ;
                  end
                  FN_RELEASE: begin
                     expect_in  = 1'b0;
                     capture_in = 1'b1;
                     phase_in   = PH_RECVED_IDLE;
                  end
                  FN_GO_IDLE: begin
                     // handled by the idle block above
                  end
                  default: begin
                     // unused code: response only
                  end
               endcase
            end
         end
         S_START: begin
            cmode_in  = CM_ARM;
            cdelay_in = mem_q;
            state_in  = S_DONE;
         end
         S_XMIT1: begin
            state_in = S_DONE;
            if (burst_ff) begin
               burst_in  = 1'b0;
               cmode_in  = CM_ADVANCE;
               cdelay_in = mem_q;
            end else if (mem_q != 16'd0) begin
               burst_in  = 1'b1;
               cmode_in  = CM_ADVANCE;
               cdelay_in = mem_q;
            end else begin
               // zero entry: skip it and take the following one as the delay
               rd_ok_in  = play_next_ok;
               mem_raddr = play_ff[AW-1:0];
               play_in   = play_ff + CNT_W'(1);
               state_in  = S_XMIT2;
            end
         end
         S_XMIT2: begin
            burst_in  = 1'b0;
            cmode_in  = CM_ADVANCE;
            cdelay_in = rd_ok_ff ? mem_q : 16'd0;
            state_in  = S_DONE;
         end
         S_READ: begin
            rdata_in = rd_ok_ff ? mem_q : 16'd0;
            state_in = S_DONE;
         end
         S_PUSH: begin
            if (count_ff < DEPTH_C) begin
               mem_we    = 1'b1;
               mem_waddr = count_ff[AW-1:0];
               mem_wdata = push_value;
               count_in  = count_ff + CNT_W'(1);
            end
            push_left_in = push_left_ff - PUSH_W'(1);
            if (push_left_ff == PUSH_W'(1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         play_ff      <= '0;
         last_edge_ff <= 16'd0;
         trailer_ff   <= 3'd0;
         expect_ff    <= 1'b0;
         capture_ff   <= 1'b1;
         compare_ff   <= 1'b0;
         burst_ff     <= 1'b0;
         freq_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         play_ff      <= play_in;
         last_edge_ff <= last_edge_in;
         trailer_ff   <= trailer_in;
         expect_ff    <= expect_in;
         capture_ff   <= capture_in;
         compare_ff   <= compare_in;
         burst_ff     <= burst_in;
         freq_ff      <= freq_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      push_left_ff <= push_left_in;
      width_ff     <= width_in;
      rd_ok_ff     <= rd_ok_in;
      rdata_ff     <= rdata_in;
      acc_ff       <= acc_in;
      cmode_ff     <= cmode_in;
      cdelay_ff    <= cdelay_in;
   end

   // Snapshot the settled state into the response register.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_mode            <= phase_ff;
         rsp_read_data       <= rdata_ff;
         rsp_accepted        <= acc_ff;
         rsp_entry_count     <= 10'(count_ff);
         rsp_carrier_on      <= burst_ff;
         rsp_carrier_40k     <= freq_ff;
         rsp_capture_enabled <= capture_ff;
         rsp_capture_rising  <= expect_ff;
         rsp_compare_mode    <= cmode_ff;
         rsp_compare_delay   <= cdelay_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `IPCR_ASSERT(a_count_bound, clock, reset, count_ff <= DEPTH_C)
   `IPCR_ASSERT_IMPLY(a_xmit_no_capture, clock, reset, phase_ff == PH_XMIT, !capture_ff)
   `IPCR_ASSERT_IMPLY(a_recved_quiet, clock, reset, phase_ff == PH_RECVED, !capture_ff && !compare_ff)
   `IPCR_ASSERT_IMPLY(a_write_timing, clock, reset, mem_we, req_fire || state_ff == S_PUSH)

endmodule
